// ===== hdl/idof_pkg.sv =====
package idof_pkg;

    // Register file geometry
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // Word widths
    localparam int WORD_W = 32;
    localparam int ALU_W  = 6;
    localparam int MEM_W  = 6;

    // Instruction formats, taken from bits 31:30
    typedef enum logic [1:0] {
        FMT_REG  = 2'd0,
        FMT_IMM  = 2'd1,
        FMT_BR   = 2'd2,
        FMT_JUMP = 2'd3
    } t_format;

    // Classes of the register format; the remaining codes decode as a plain ALU op 0
    typedef enum logic [3:0] {
        CLS_ALU0 = 4'd0,
        CLS_ALU1 = 4'd1,
        CLS_ALU2 = 4'd2,
        CLS_MEM  = 4'd3,
        CLS_CALL = 4'd4,
        CLS_RET  = 4'd5,
        CLS_SYS  = 4'd6
    } t_class;

    // Immediate-format opcodes that do not map straight onto the ALU code
    localparam logic [3:0] OPC_ALT  = 4'd13;
    localparam logic [3:0] OPC_LINK = 4'd14;

    // ALU codes and offsets
    localparam logic [ALU_W-1:0] ALU_NOP      = 6'd0;
    localparam logic [ALU_W-1:0] ALU_OFS_CLS1 = 6'd6;
    localparam logic [ALU_W-1:0] ALU_OFS_CLS2 = 6'd18;
    localparam logic [ALU_W-1:0] ALU_OFS_BR   = 6'd18;
    localparam logic [ALU_W-1:0] ALU_PASS     = 6'd16;
    localparam logic [ALU_W-1:0] ALU_ALT      = 6'd17;

    // Memory access codes
    localparam logic signed [MEM_W-1:0] MEM_NONE  = -6'sd1;
    localparam logic [4:0]              MEM_NEAR_MAX = 5'd2;

    // Target sentinels
    localparam logic [WORD_W-1:0] TGT_FAR  = 32'd1000;
    localparam logic [WORD_W-1:0] TGT_LINK = 32'd33;
    localparam logic [WORD_W-1:0] TGT_RA   = 32'd31;

    // Port packing
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 152;

    // One decoded result
    typedef struct packed {
        logic [ALU_W-1:0]        alu_op;
        logic [WORD_W-1:0]       operand_a;
        logic [WORD_W-1:0]       operand_b;
        logic [WORD_W-1:0]       target;
        logic signed [MEM_W-1:0] mem_access;
        logic                    jump;
        logic [WORD_W-1:0]       pc_out;
        logic [1:0]              format;
        logic [3:0]              op_class;
    } t_dec_result;

    // Everything the decoder needs for one instruction
    typedef struct packed {
        logic [WORD_W-1:0] instr;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] reg_a;
        logic [WORD_W-1:0] reg_b;
        logic [WORD_W-1:0] reg_ra;
        logic [3:0]        last_class;
    } t_dec_source;

endpackage

// ===== hdl/instruction_decode_operand_fetch.sv =====
// Decode and operand-fetch stage. Each input word is either a register file
// write (tuser low) or an instruction with its PC (tuser high). Register
// writes give no output word; every instruction gives exactly one output word.
// One word is accepted per clock, and the rate stays at one per clock as long
// as the output side takes its words; the two register stages between the
// ports are the register file read and the result register. The register file
// is a two-read-port memory whose entries read as zero after reset until
// written, so no clearing pass is needed and the block is ready right out of
// reset. A write followed by an instruction in the next cycle already sees the
// new value.
module instruction_decode_operand_fetch (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: instruction[31:0], pc_in[63:32], reg_index[68:64], reg_data[100:69], zero pad
    input  logic [idof_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: cmd[0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: alu_op[5:0], operand_a[37:6], operand_b[69:38], target[101:70],
    // mem_access[107:102], jump[108], pc_out[140:109], format[142:141],
    // op_class[146:143], zero pad
    output logic [idof_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import idof_pkg::*;

    logic                 s_accept;
    logic                 dec_accept;
    logic                 wr_accept;
    logic                 s1_advance;
    logic                 r_s1_valid;
    logic                 n_s1_valid;
    logic [WORD_W-1:0]    r_s1_instr;
    logic [WORD_W-1:0]    r_s1_pc;
    logic [3:0]           r_last_class;
    logic [3:0]           n_last_class;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_dec_result          r_out;
    t_dec_result          dec_res;
    t_dec_source          dec_src;
    logic [WORD_W-1:0]    rdata_a;
    logic [WORD_W-1:0]    rdata_b;
    logic [WORD_W-1:0]    rdata_ra;

    // Handshake and flow control
    assign s1_advance = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign dec_accept = s_accept && i_s_tuser;
    assign wr_accept  = s_accept && !i_s_tuser;

    // Register file with registered reads
    idof_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (wr_accept),
        .i_waddr    (i_s_tdata[68:64]),
        .i_wdata    (i_s_tdata[100:69]),
        .i_re       (dec_accept),
        .i_raddr_a  (i_s_tdata[25:21]),
        .i_raddr_b  (i_s_tdata[20:16]),
        .o_rdata_a  (rdata_a),
        .o_rdata_b  (rdata_b),
        .o_rdata_ra (rdata_ra)
    );

    // Fetch stage: the instruction waits here while its operands are read
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s_accept) begin
            n_s1_valid = i_s_tuser;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_accept) begin
            r_s1_instr <= i_s_tdata[31:0];
            r_s1_pc    <= i_s_tdata[63:32];
        end
    end

    // Decode
    assign dec_src = '{
        instr:      r_s1_instr,
        pc:         r_s1_pc,
        reg_a:      rdata_a,
        reg_b:      rdata_b,
        reg_ra:     rdata_ra,
        last_class: r_last_class
    };

    idof_decode u_decode (
        .i_src (dec_src),
        .o_res (dec_res)
    );

    // The class of the latest register-format instruction is remembered
    assign n_last_class = s1_advance ? dec_res.op_class : r_last_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_class <= '0;
        end else begin
            r_last_class <= n_last_class;
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if (s1_advance) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= dec_res;
        end
    end

    // Output packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        5'd0,
        r_out.op_class,
        r_out.format,
        r_out.pc_out,
        r_out.jump,
        r_out.mem_access,
        r_out.target,
        r_out.operand_b,
        r_out.operand_a,
        r_out.alu_op
    };

endmodule

// ===== hdl/idof_regfile.sv =====
module idof_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [idof_pkg::REG_IDX_W-1:0]  i_waddr,
    input  logic [idof_pkg::WORD_W-1:0]     i_wdata,
    input  logic                            i_re,
    input  logic [idof_pkg::REG_IDX_W-1:0]  i_raddr_a,
    input  logic [idof_pkg::REG_IDX_W-1:0]  i_raddr_b,
    output logic [idof_pkg::WORD_W-1:0]     o_rdata_a,
    output logic [idof_pkg::WORD_W-1:0]     o_rdata_b,
    output logic [idof_pkg::WORD_W-1:0]     o_rdata_ra
);
    import idof_pkg::*;

    localparam logic [REG_IDX_W-1:0] RA_IDX = REG_IDX_W'(REG_COUNT - 1);

    logic [WORD_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [WORD_W-1:0]    r_ra_shadow;
    logic [WORD_W-1:0]    r_rdata_a;
    logic [WORD_W-1:0]    r_rdata_b;
    logic [WORD_W-1:0]    r_rdata_ra;

    // Storage array, written one entry per word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Entries read as zero until written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // The return-address entry is also kept in a register of its own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra_shadow <= '0;
        end else if (i_we && (i_waddr == RA_IDX)) begin
            r_ra_shadow <= i_wdata;
        end
    end

    // Registered reads, taken when an instruction word is accepted
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a  <= r_valid[i_raddr_a] ? r_mem[i_raddr_a] : '0;
            r_rdata_b  <= r_valid[i_raddr_b] ? r_mem[i_raddr_b] : '0;
            r_rdata_ra <= r_ra_shadow;
        end
    end

    assign o_rdata_a  = r_rdata_a;
    assign o_rdata_b  = r_rdata_b;
    assign o_rdata_ra = r_rdata_ra;

endmodule

// ===== hdl/idof_decode.sv =====
module idof_decode (
    input  idof_pkg::t_dec_source i_src,
    output idof_pkg::t_dec_result o_res
);
    import idof_pkg::*;

    logic [1:0]        fmt;
    logic [3:0]        hi4;
    logic [4:0]        rb;
    logic [4:0]        rd;
    logic [4:0]        op5;
    logic [WORD_W-1:0] imm;

    // Instruction fields
    assign fmt = i_src.instr[31:30];
    assign hi4 = i_src.instr[29:26];
    assign rb  = i_src.instr[20:16];
    assign rd  = i_src.instr[15:11];
    assign op5 = i_src.instr[10:6];
    assign imm = {{16{i_src.instr[15]}}, i_src.instr[15:0]};

    // Format and class decode
    always_comb begin
        o_res            = '0;
        o_res.operand_a  = i_src.reg_a;
        o_res.operand_b  = i_src.reg_b;
        o_res.mem_access = MEM_NONE;
        o_res.pc_out     = i_src.pc;
        o_res.format     = fmt;
        o_res.op_class   = i_src.last_class;
        case (t_format'(fmt))
            FMT_REG: begin
                o_res.op_class = hi4;
                o_res.target   = {27'd0, rd};
                case (t_class'(hi4))
                    CLS_ALU0: o_res.alu_op = {1'b0, op5};
                    CLS_ALU1: o_res.alu_op = {1'b0, op5} + ALU_OFS_CLS1;
                    CLS_ALU2: o_res.alu_op = {1'b0, op5} + ALU_OFS_CLS2;
                    CLS_MEM: begin
                        o_res.alu_op     = ALU_PASS;
                        o_res.mem_access = {1'b0, op5};
                        if (op5 > MEM_NEAR_MAX) begin
                            o_res.target = TGT_FAR;
                        end
                    end
                    CLS_CALL: begin
                        o_res.alu_op    = ALU_NOP;
                        o_res.jump      = 1'b1;
                        o_res.operand_a = i_src.pc;
                        o_res.operand_b = 32'd1;
                        o_res.pc_out    = i_src.reg_a;
                    end
                    CLS_RET: begin
                        o_res.alu_op = ALU_PASS;
                        o_res.jump   = 1'b1;
                        o_res.target = TGT_FAR;
                        o_res.pc_out = i_src.reg_ra;
                    end
                    CLS_SYS: begin
                        o_res.alu_op = ALU_PASS;
                        o_res.target = TGT_FAR;
                    end
                    default: o_res.alu_op = ALU_NOP;
                endcase
            end
            FMT_IMM: begin
                o_res.operand_b = imm;
                o_res.target    = {27'd0, rb};
                if (hi4 == OPC_LINK) begin
                    o_res.alu_op    = ALU_NOP;
                    o_res.target    = TGT_LINK;
                    o_res.operand_a = i_src.pc;
                end else if (hi4 == OPC_ALT) begin
                    o_res.alu_op = ALU_ALT;
                end else begin
                    o_res.alu_op = {2'b00, hi4};
                end
            end
            FMT_BR: begin
                o_res.target = imm;
                o_res.alu_op = {2'b00, hi4} + ALU_OFS_BR;
            end
            default: begin
                o_res.alu_op    = ALU_NOP;
                o_res.jump      = 1'b1;
                o_res.target    = TGT_RA;
                o_res.operand_a = i_src.pc;
                o_res.operand_b = 32'd1;
                o_res.pc_out    = {2'b00, i_src.instr[29:0]};
            end
        endcase
    end

endmodule

// ===== hdl/idof_checker.sv =====
module idof_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [idof_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import idof_pkg::*;

    // A stalled output word stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output word changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // Only register-format instructions access memory
    a_mem_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[142:141] != FMT_REG)) |->
        (o_m_tdata[107:102] == MEM_NONE))
        else $error("memory access on a non-register format");

    // Jump format always links through the return register
    a_jump_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[142:141] == FMT_JUMP)) |->
        (o_m_tdata[108] && (o_m_tdata[101:70] == TGT_RA) && (o_m_tdata[69:38] == 32'd1)))
        else $error("jump format decoded wrongly");

    // With the output stalled and the fetch stage full, no write or instruction is taken
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && i_s_tvalid && i_s_tuser && o_s_tready)
        |=> (!i_m_tready && o_m_tvalid) |-> !o_s_tready)
        else $error("input taken with both stages full");

endmodule

bind instruction_decode_operand_fetch idof_checker u_idof_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
